// File: rtl/ccs_pkg.sv
// Package for the co-clustering similarity block: field widths, command and
// state codes, and the control and status bundles between controller and datapath.
// Used by ccs_ctrl, ccs_dp and the top level; depends on nothing.
`default_nettype none

package ccs_pkg;

   localparam int MAX_SUBJECTS_DEF = 16;
   localparam int LABEL_BITS_DEF   = 16;
   localparam int COUNT_BITS_DEF   = 16;

   localparam int SUBJECT_W    = 4;
   localparam int LABEL_W      = 16;
   localparam int CMD_W        = 2;
   localparam int OUT_W        = 16;
   localparam int SIM_W        = 17;
   localparam int FRAC_BITS    = 16;
   localparam int NUM_SUBJ_W   = 5;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 56;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [NUM_SUBJ_W-1:0] NUM_SUBJ_RESET   = 5'd16;
   localparam logic [SIM_W-1:0]      SIM_ONE          = 17'h10000;
   localparam logic                  REG_NUM_SUBJECTS = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_LOAD,
      ST_DRAIN,
      ST_RD_DATA,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic clear_start;
      logic clr_step;
      logic load_start;
      logic load_issue;
      logic rd_issue;
      logic div_setup;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type item_cmd;
      logic    load_in_use;
      logic    issue_done;
      logic    pipe_empty;
      logic    clr_done;
      logic    need_div;
      logic    div_done;
      logic    out_free;
   } ctrl_stat_type;

endpackage

`default_nettype wire

// File: rtl/ccs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the row label buffer and the pair counters.
`default_nettype none

module ccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/ccs_ctrl.sv
// Controller state machine of the co-clustering similarity block.
// Depends on ccs_pkg; drives the datapath through ctrl_cmd_type.
`default_nettype none

module ccs_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire ccs_pkg::ctrl_stat_type stat,
   output ccs_pkg::ctrl_cmd_type       cmd
);

   ccs_pkg::state_type state_ff;
   ccs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ccs_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) begin
               state_in = ccs_pkg::ST_IDLE;
            end
         end
         ccs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ccs_pkg::ST_DECODE;
            end
         end
         ccs_pkg::ST_DECODE: begin
            unique case (stat.item_cmd)
               ccs_pkg::CMD_CLEAR: begin
                  cmd.clear_start = 1'b1;
                  state_in        = ccs_pkg::ST_CLEAR;
               end
               ccs_pkg::CMD_LOAD: begin
                  if (stat.load_in_use) begin
                     cmd.load_start = 1'b1;
                     state_in       = ccs_pkg::ST_LOAD;
                  end else begin
                     state_in = ccs_pkg::ST_IDLE;
                  end
               end
               ccs_pkg::CMD_READ: begin
                  cmd.rd_issue = 1'b1;
                  state_in     = ccs_pkg::ST_RD_DATA;
               end
               default: begin
                  state_in = ccs_pkg::ST_IDLE;
               end
            endcase
         end
         ccs_pkg::ST_LOAD: begin
            if (stat.issue_done) begin
               state_in = ccs_pkg::ST_DRAIN;
            end else begin
               cmd.load_issue = 1'b1;
            end
         end
         ccs_pkg::ST_DRAIN: begin
            if (stat.pipe_empty) begin
               state_in = ccs_pkg::ST_IDLE;
            end
         end
         ccs_pkg::ST_RD_DATA: begin
            cmd.div_setup = 1'b1;
            state_in = stat.need_div ? ccs_pkg::ST_DIV : ccs_pkg::ST_DONE;
         end
         ccs_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = ccs_pkg::ST_DONE;
            end
         end
         ccs_pkg::ST_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ccs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ccs_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_clear_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ccs_pkg::ST_CLEAR) && !stat.clr_done |=> (state_ff == ccs_pkg::ST_CLEAR))
      else $error("clear sweep left before the last counter was zeroed");
`endif

endmodule

`default_nettype wire

// File: rtl/ccs_dp.sv
// Datapath of the co-clustering similarity block: item register, row label
// buffer, pair counter memory, iteration counter, divider and result register.
// Depends on ccs_pkg and ccs_ram; steered by ccs_ctrl.
`default_nettype none

module ccs_dp #(
   parameter int MAX_SUBJECTS = ccs_pkg::MAX_SUBJECTS_DEF,
   parameter int LABEL_BITS   = ccs_pkg::LABEL_BITS_DEF,
   parameter int COUNT_BITS   = ccs_pkg::COUNT_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ccs_pkg::ctrl_cmd_type             cmd,
   output ccs_pkg::ctrl_stat_type                 stat,
   input  wire logic [ccs_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [ccs_pkg::CMD_W-1:0]         req_tuser,
   input  wire logic [ccs_pkg::NUM_SUBJ_W-1:0]    num_subjects,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [ccs_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int SW  = $clog2(MAX_SUBJECTS);
   localparam int PAW = 2 * SW;
   localparam int PDEPTH = 1 << PAW;
   localparam int LW  = (LABEL_BITS < ccs_pkg::LABEL_W) ? LABEL_BITS : ccs_pkg::LABEL_W;
   localparam int CW  = COUNT_BITS;
   localparam int NW  = ($clog2(MAX_SUBJECTS + 1) > ccs_pkg::NUM_SUBJ_W) ?
                        $clog2(MAX_SUBJECTS + 1) : ccs_pkg::NUM_SUBJ_W;
   localparam int DCW = $clog2(ccs_pkg::FRAC_BITS);
   localparam int PADW = ccs_pkg::RSP_DATA_W - 2 * ccs_pkg::OUT_W - ccs_pkg::SIM_W;

   function automatic logic [ccs_pkg::OUT_W-1:0] sat16(input logic [CW-1:0] v);
      logic [ccs_pkg::OUT_W-1:0] r;
      if (v > CW'(32'h0000_FFFF)) begin
         r = '1;
      end else begin
         r = ccs_pkg::OUT_W'(v);
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      return (v == '1) ? v : v + CW'(1);
   endfunction

   logic [ccs_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   logic [ccs_pkg::SUBJECT_W-1:0] subj_ff, subj_in;
   logic [ccs_pkg::SUBJECT_W-1:0] other_ff, other_in;
   logic [LW-1:0]                 label_ff, label_in;

   logic [SW-1:0]  t_ff, t_in;
   logic [SW-1:0]  t1_ff, t1_in;
   logic           p1_ff, p1_in;
   logic           p2_ff, p2_in;
   logic [PAW-1:0] pa2_ff, pa2_in;
   logic [PAW-1:0] clr_addr_ff, clr_addr_in;
   logic [CW-1:0]  iter_ff, iter_in;

   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [CW-1:0]            rem_ff, rem_in;
   logic [ccs_pkg::SIM_W-1:0] sim_ff, sim_in;
   logic [DCW-1:0]           div_cnt_ff, div_cnt_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ccs_pkg::OUT_W-1:0] out_cnt_ff, out_cnt_in;
   logic [ccs_pkg::SIM_W-1:0] out_sim_ff, out_sim_in;
   logic [ccs_pkg::OUT_W-1:0] out_iter_ff, out_iter_in;

   logic [NW-1:0] n_raw, n_use, subj_w;
   logic          load_in_use, load_last, match;
   logic [LW-1:0] lbl_rdata;
   logic [CW-1:0] pair_rdata;
   logic [PAW-1:0] pair_rd_addr, pair_wr_addr;
   logic [CW-1:0]  pair_wr_data;
   logic           pair_wr_en;
   logic [ccs_pkg::SUBJECT_W-1:0] lo, hi;
   logic          diag, hi_ok;
   logic [CW-1:0] cnt_sel;
   logic [CW:0]   rem_dbl, rem_sub;
   logic          rem_ge;

   // Subjects in use, clamped to one through MAX_SUBJECTS.
   always_comb begin
      n_raw = NW'(num_subjects);
      if (n_raw == '0) begin
         n_use = NW'(1);
      end else if (n_raw > NW'(MAX_SUBJECTS)) begin
         n_use = NW'(MAX_SUBJECTS);
      end else begin
         n_use = n_raw;
      end
      subj_w      = NW'(subj_ff);
      load_in_use = subj_w < n_use;
      load_last   = subj_w == (n_use - NW'(1));
   end

   ccs_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_SUBJECTS)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (cmd.load_start),
      .wr_addr (SW'(subj_ff)),
      .wr_data (label_ff),
      .rd_addr (t_ff),
      .rd_data (lbl_rdata)
   );

   ccs_ram #(
      .WIDTH (CW),
      .DEPTH (PDEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_wr_en),
      .wr_addr (pair_wr_addr),
      .wr_data (pair_wr_data),
      .rd_addr (pair_rd_addr),
      .rd_data (pair_rdata)
   );

   always_comb begin
      match = p1_ff && (lbl_rdata == label_ff);
      lo    = (subj_ff < other_ff) ? subj_ff : other_ff;
      hi    = (subj_ff < other_ff) ? other_ff : subj_ff;
      diag  = subj_ff == other_ff;
      hi_ok = NW'(hi) < NW'(MAX_SUBJECTS);
      if (cmd.rd_issue) begin
         pair_rd_addr = {SW'(lo), SW'(hi)};
      end else begin
         pair_rd_addr = {t1_ff, SW'(subj_ff)};
      end
      pair_wr_en = cmd.clr_step || p2_ff;
      if (cmd.clr_step) begin
         pair_wr_addr = clr_addr_ff;
         pair_wr_data = '0;
      end else begin
         pair_wr_addr = pa2_ff;
         pair_wr_data = sat_inc(pair_rdata);
      end
      if (diag) begin
         cnt_sel = iter_ff;
      end else if (hi_ok) begin
         cnt_sel = pair_rdata;
      end else begin
         cnt_sel = '0;
      end
      rem_dbl = {rem_ff, 1'b0};
      rem_sub = rem_dbl - {1'b0, iter_ff};
      rem_ge  = rem_dbl >= {1'b0, iter_ff};
   end

   always_comb begin
      cmd_in      = cmd_ff;
      subj_in     = subj_ff;
      other_in    = other_ff;
      label_in    = label_ff;
      t_in        = t_ff;
      t1_in       = t1_ff;
      p1_in       = cmd.load_issue;
      p2_in       = match;
      pa2_in      = pair_rd_addr;
      clr_addr_in = clr_addr_ff;
      iter_in     = iter_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      sim_in      = sim_ff;
      div_cnt_in  = div_cnt_ff;
      out_cnt_in  = out_cnt_ff;
      out_sim_in  = out_sim_ff;
      out_iter_in = out_iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.accept) begin
         cmd_in   = req_tuser;
         subj_in  = req_tdata[3:0];
         other_in = req_tdata[7:4];
         label_in = req_tdata[8 +: LW];
      end
      if (cmd.clear_start) begin
         iter_in     = '0;
         clr_addr_in = '0;
      end
      if (cmd.clr_step) begin
         clr_addr_in = clr_addr_ff + PAW'(1);
      end
      if (cmd.load_start) begin
         t_in = '0;
         if (load_last) begin
            iter_in = sat_inc(iter_ff);
         end
      end
      if (cmd.load_issue) begin
         t1_in = t_ff;
         t_in  = t_ff + SW'(1);
      end
      if (cmd.div_setup) begin
         cnt_in     = cnt_sel;
         rem_in     = cnt_sel;
         div_cnt_in = '0;
         if (diag) begin
            sim_in = ccs_pkg::SIM_ONE;
         end else if (iter_ff == '0) begin
            sim_in = '0;
         end else if (cnt_sel >= iter_ff) begin
            sim_in = ccs_pkg::SIM_ONE;
         end else begin
            sim_in = '0;
         end
      end
      if (cmd.div_step) begin
         rem_in     = rem_ge ? CW'(rem_sub) : CW'(rem_dbl);
         sim_in     = {sim_ff[ccs_pkg::SIM_W-2:0], rem_ge};
         div_cnt_in = div_cnt_ff + DCW'(1);
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         out_cnt_in   = sat16(cnt_ff);
         out_sim_in   = sim_ff;
         out_iter_in  = sat16(iter_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         t_ff         <= '0;
         clr_addr_ff  <= '0;
         iter_ff      <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         t_ff         <= t_in;
         clr_addr_ff  <= clr_addr_in;
         iter_ff      <= iter_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      subj_ff     <= subj_in;
      other_ff    <= other_in;
      label_ff    <= label_in;
      t1_ff       <= t1_in;
      pa2_ff      <= pa2_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      sim_ff      <= sim_in;
      out_cnt_ff  <= out_cnt_in;
      out_sim_ff  <= out_sim_in;
      out_iter_ff <= out_iter_in;
   end

   always_comb begin
      stat.item_cmd    = ccs_pkg::cmd_type'(cmd_ff);
      stat.load_in_use = load_in_use;
      stat.issue_done  = NW'(t_ff) == subj_w;
      stat.pipe_empty  = !p1_ff && !p2_ff;
      stat.clr_done    = clr_addr_ff == PAW'(PDEPTH - 1);
      stat.need_div    = !diag && (iter_ff != '0) && (cnt_sel < iter_ff);
      stat.div_done    = div_cnt_ff == DCW'(ccs_pkg::FRAC_BITS - 1);
      stat.out_free    = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PADW{1'b0}}, out_iter_ff, out_sim_ff, out_cnt_ff};

`ifndef SYNTHESIS
   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      p2_ff |-> $past(p1_ff))
      else $error("counter update without a preceding label compare");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < iter_ff))
      else $error("divider remainder reached the iteration count");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// File: rtl/co_clustering_similarity.sv
// Top level of the co-clustering similarity block: configuration register and
// the controller and datapath instances. Depends on ccs_pkg, ccs_ctrl, ccs_dp.
//
//   Port group  Direction  Carries
//   req_*       in         tdata: subject[3:0], other_subject[7:4], label[23:8];
//                          tuser: cmd[1:0]
//   rsp_*       out        tdata: pair_count[15:0], similarity_q16[32:16],
//                          iterations[48:33], zero fill [55:49]
//   csr_*       in/out     register num_subjects at byte address 0
//
// A load of subject s reads the row label buffer once per earlier subject, and each
// match does a read-modify-write of its pair counter through the single read and
// write port. A read uses the 16-step divider only when the similarity needs it.
// After reset and after a clear item, a sweep zeroes the counter memory one entry
// per cycle, all 2**(2*ceil(log2(MAX_SUBJECTS))) entries (256 by default), with
// req_tready low. A waiting result holds only the last step of the next read.
`default_nettype none

module co_clustering_similarity #(
   parameter int MAX_SUBJECTS = ccs_pkg::MAX_SUBJECTS_DEF,
   parameter int LABEL_BITS   = ccs_pkg::LABEL_BITS_DEF,
   parameter int COUNT_BITS   = ccs_pkg::COUNT_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // subject[3:0], other_subject[7:4], label[23:8]
   input  wire logic [ccs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd[1:0]
   input  wire logic [ccs_pkg::CMD_W-1:0]        req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // pair_count[15:0], similarity_q16[32:16], iterations[48:33], zeros[55:49]
   output logic      [ccs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [ccs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [ccs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [ccs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   logic [ccs_pkg::NUM_SUBJ_W-1:0] num_subjects_ff, num_subjects_in;
   logic                           csr_hit;
   ccs_pkg::ctrl_cmd_type          cmd;
   ccs_pkg::ctrl_stat_type         stat;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[2] == ccs_pkg::REG_NUM_SUBJECTS;

   always_comb begin
      num_subjects_in = num_subjects_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         num_subjects_in = csr_pwdata[ccs_pkg::NUM_SUBJ_W-1:0];
      end
      csr_prdata = csr_hit ? ccs_pkg::CSR_DATA_W'(num_subjects_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_subjects_ff <= ccs_pkg::NUM_SUBJ_RESET;
      end else begin
         num_subjects_ff <= num_subjects_in;
      end
   end

   ccs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ccs_dp #(
      .MAX_SUBJECTS (MAX_SUBJECTS),
      .LABEL_BITS   (LABEL_BITS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .num_subjects (num_subjects_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

`default_nettype wire
